[rtl/tcr_pkg.sv]
// Shared widths, state types and token class codes for the token class recognizer.
package tcr_pkg;

	localparam int BYTE_W  = 8;
	localparam int CLASS_W = 4;

	typedef logic [BYTE_W-1:0]  byte_t;
	typedef logic [CLASS_W-1:0] class_t;

	// token class codes
	localparam class_t CLS_INVALID = 4'd0;
	localparam class_t CLS_SCI     = 4'd1;
	localparam class_t CLS_DEC     = 4'd2;
	localparam class_t CLS_INT     = 4'd3;
	localparam class_t CLS_KW      = 4'd4;
	localparam class_t CLS_HEX     = 4'd5;
	localparam class_t CLS_CHR     = 4'd6;
	localparam class_t CLS_AIR     = 4'd7;
	localparam class_t CLS_IDENT   = 4'd8;
	localparam class_t CLS_STR     = 4'd9;
	localparam class_t CLS_PHONE   = 4'd10;

	// recognizer state vectors, all-ones is the dead state
	typedef logic [1:0] st2_t;
	typedef logic [2:0] st3_t;
	typedef logic [3:0] st4_t;
	typedef logic [4:0] st5_t;

	localparam st2_t DEAD2 = 2'd3;
	localparam st3_t DEAD3 = 3'd7;
	localparam st4_t DEAD4 = 4'd15;
	localparam st5_t DEAD5 = 5'd31;

	// character constants
	localparam byte_t CH_E     = 8'h45;
	localparam byte_t CH_H     = 8'h48;
	localparam byte_t CH_X     = 8'h58;
	localparam byte_t CH_DOT   = 8'h2E;
	localparam byte_t CH_UNDER = 8'h5F;
	localparam byte_t CH_MINUS = 8'h2D;
	localparam byte_t CH_PLUS  = 8'h2B;
	localparam byte_t CH_QUOTE = 8'h22;
	localparam byte_t CH_SPACE = 8'h20;
	localparam byte_t CH_LPAR  = 8'h28;
	localparam byte_t CH_RPAR  = 8'h29;
	localparam byte_t CH_ZERO  = 8'h30;

endpackage

[rtl/token_class_recognizer.sv]
// Token class recognizer: ten byte-wide recognizers and a registered class result.
//
// Usage: the bytes of one token arrive on token_byte with byte_valid, the final
// byte flagged by token_last. A byte is taken at a clock edge with byte_valid
// high and byte_stall low. Ten small state machines advance on every byte; on
// the flagged byte the first accepting class (scientific, decimal, integer,
// keyword, hex, char, aircraft, identifier, string, phone) or invalid is
// registered onto token_class with class_valid, and all machines restart.
// Bytes without token_last give no result.
// A final byte passes the input register, then the result register, before its
// result shows on token_class; it can leave while class_stall is low.
// Throughput: one byte per cycle while byte_stall is low, set by the single pass
// of next-state logic between those two registers.
// class_stall holds the result; the held byte in the input register then waits
// only if it is a final byte, and byte_stall rises while it waits. A result
// leaving in the same cycle frees the slot at once.
// Reset (arst_n low, asynchronous) empties both registers and puts every
// recognizer in its start state.
module token_class_recognizer (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           byte_valid,
	output logic           byte_stall,
	input  tcr_pkg::byte_t token_byte,
	input  logic           token_last,
	output logic           class_valid,
	input  logic           class_stall,
	output tcr_pkg::class_t token_class
);
	import tcr_pkg::*;

	// character classes
	function automatic logic is_dig(input byte_t c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction
	function automatic logic is_alpha(input byte_t c);
		return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
	endfunction
	function automatic logic is_hexd(input byte_t c);
		return is_dig(c) || (c >= 8'h41 && c <= 8'h46);
	endfunction
	function automatic logic is_sign(input byte_t c);
		return c == CH_MINUS || c == CH_PLUS;
	endfunction
	function automatic logic is_air1(input byte_t c);
		return c == 8'h41 || c == 8'h47 || c == 8'h4A || c == 8'h44 || c == 8'h50
			|| c == 8'h4C;
	endfunction
	function automatic logic is_air2(input byte_t c);
		return c == 8'h41 || c == 8'h4B || c == 8'h4D || c == 8'h4E || c == 8'h59;
	endfunction

	// scientific number
	function automatic st4_t nx_sci(input st4_t s, input byte_t c);
		st4_t n;
		n = DEAD4;
		unique case (s)
			4'd0: n = is_dig(c) ? 4'd2 : is_sign(c) ? 4'd1 : DEAD4;
			4'd1: n = is_dig(c) ? 4'd2 : DEAD4;
			4'd2: n = is_dig(c) ? 4'd2 : (c == CH_DOT) ? 4'd3 : DEAD4;
			4'd3: n = is_dig(c) ? 4'd4 : DEAD4;
			4'd4: n = is_dig(c) ? 4'd4 : (c == CH_E) ? 4'd5 : DEAD4;
			4'd5: n = (is_dig(c) && c != CH_ZERO) ? 4'd7 : is_sign(c) ? 4'd6 : DEAD4;
			4'd6: n = (is_dig(c) && c != CH_ZERO) ? 4'd7 : DEAD4;
			4'd7: n = is_dig(c) ? 4'd7 : DEAD4;
			default: n = DEAD4;
		endcase
		return n;
	endfunction

	// decimal
	function automatic st3_t nx_dec(input st3_t s, input byte_t c);
		st3_t n;
		n = DEAD3;
		unique case (s)
			3'd0: n = is_dig(c) ? 3'd2 : is_sign(c) ? 3'd1 : DEAD3;
			3'd1: n = is_dig(c) ? 3'd2 : DEAD3;
			3'd2: n = is_dig(c) ? 3'd2 : (c == CH_DOT) ? 3'd3 : DEAD3;
			3'd3, 3'd4: n = is_dig(c) ? 3'd4 : DEAD3;
			default: n = DEAD3;
		endcase
		return n;
	endfunction

	// integer
	function automatic st2_t nx_int(input st2_t s, input byte_t c);
		st2_t n;
		n = DEAD2;
		unique case (s)
			2'd0: n = is_dig(c) ? 2'd2 : is_sign(c) ? 2'd1 : DEAD2;
			2'd1, 2'd2: n = is_dig(c) ? 2'd2 : DEAD2;
			default: n = DEAD2;
		endcase
		return n;
	endfunction

	// keywords FUNCTION, IF, ELSE, END, WHILE, WRITE
	function automatic st5_t nx_kw(input st5_t s, input byte_t c);
		st5_t n;
		n = DEAD5;
		unique case (s)
			5'd0: n = (c == 8'h46) ? 5'd1 : (c == 8'h49) ? 5'd9 :
				(c == CH_E) ? 5'd11 : (c == 8'h57) ? 5'd17 : DEAD5;
			5'd1:  n = (c == 8'h55) ? 5'd2 : DEAD5;
			5'd2:  n = (c == 8'h4E) ? 5'd3 : DEAD5;
			5'd3:  n = (c == 8'h43) ? 5'd4 : DEAD5;
			5'd4:  n = (c == 8'h54) ? 5'd5 : DEAD5;
			5'd5:  n = (c == 8'h49) ? 5'd6 : DEAD5;
			5'd6:  n = (c == 8'h4F) ? 5'd7 : DEAD5;
			5'd7:  n = (c == 8'h4E) ? 5'd8 : DEAD5;
			5'd9:  n = (c == 8'h46) ? 5'd10 : DEAD5;
			5'd11: n = (c == 8'h4C) ? 5'd12 : (c == 8'h4E) ? 5'd15 : DEAD5;
			5'd12: n = (c == 8'h53) ? 5'd13 : DEAD5;
			5'd13: n = (c == CH_E) ? 5'd14 : DEAD5;
			5'd15: n = (c == 8'h44) ? 5'd16 : DEAD5;
			5'd17: n = (c == CH_H) ? 5'd18 : (c == 8'h52) ? 5'd22 : DEAD5;
			5'd18: n = (c == 8'h49) ? 5'd19 : DEAD5;
			5'd19: n = (c == 8'h4C) ? 5'd20 : DEAD5;
			5'd20: n = (c == CH_E) ? 5'd21 : DEAD5;
			5'd22: n = (c == 8'h49) ? 5'd23 : DEAD5;
			5'd23: n = (c == 8'h54) ? 5'd24 : DEAD5;
			5'd24: n = (c == CH_E) ? 5'd25 : DEAD5;
			default: n = DEAD5;
		endcase
		return n;
	endfunction

	// hexadecimal with H suffix
	function automatic st2_t nx_hex(input st2_t s, input byte_t c);
		st2_t n;
		n = DEAD2;
		unique case (s)
			2'd0: n = is_hexd(c) ? 2'd1 : DEAD2;
			2'd1: n = is_hexd(c) ? 2'd1 : (c == CH_H) ? 2'd2 : DEAD2;
			default: n = DEAD2;
		endcase
		return n;
	endfunction

	// character literal: two hex digits then X
	function automatic st3_t nx_chr(input st3_t s, input byte_t c);
		st3_t n;
		n = DEAD3;
		unique case (s)
			3'd0: n = is_hexd(c) ? 3'd1 : DEAD3;
			3'd1: n = is_hexd(c) ? 3'd2 : DEAD3;
			3'd2: n = (c == CH_X) ? 3'd3 : DEAD3;
			default: n = DEAD3;
		endcase
		return n;
	endfunction

	// aircraft code
	function automatic st4_t nx_air(input st4_t s, input byte_t c);
		st4_t n;
		n = DEAD4;
		unique case (s)
			4'd0: n = is_air1(c) ? 4'd1 : DEAD4;
			4'd1: n = is_dig(c) ? 4'd2 : DEAD4;
			4'd2: n = is_dig(c) ? 4'd3 : is_air2(c) ? 4'd4 : DEAD4;
			4'd3: n = is_air2(c) ? 4'd4 : DEAD4;
			4'd4: n = is_dig(c) ? 4'd5 : DEAD4;
			4'd5: n = (c == CH_MINUS) ? 4'd7 : is_dig(c) ? 4'd6 : DEAD4;
			4'd6: n = (c == CH_MINUS) ? 4'd7 : DEAD4;
			4'd7: n = is_air1(c) ? 4'd8 : DEAD4;
			default: n = DEAD4;
		endcase
		return n;
	endfunction

	// identifier
	function automatic st2_t nx_ident(input st2_t s, input byte_t c);
		st2_t n;
		n = DEAD2;
		unique case (s)
			2'd0: n = is_alpha(c) ? 2'd1 : DEAD2;
			2'd1: n = (is_alpha(c) || is_dig(c) || c == CH_UNDER) ? 2'd1 : DEAD2;
			default: n = DEAD2;
		endcase
		return n;
	endfunction

	// string literal, no spaces inside
	function automatic st3_t nx_str(input st3_t s, input byte_t c);
		st3_t n;
		logic body;
		body = c != CH_SPACE && c != CH_QUOTE;
		n = DEAD3;
		unique case (s)
			3'd0: n = (c == CH_QUOTE) ? 3'd1 : DEAD3;
			3'd1: n = body ? 3'd2 : DEAD3;
			3'd2: n = body ? 3'd2 : (c == CH_QUOTE) ? 3'd3 : DEAD3;
			default: n = DEAD3;
		endcase
		return n;
	endfunction

	// phone number: digit runs with separators
	function automatic st5_t nx_phone(input st5_t s, input byte_t c);
		st5_t n;
		logic d;
		d = is_dig(c);
		n = DEAD5;
		unique case (s)
			5'd0:  n = d ? 5'd1 : (c == CH_LPAR) ? 5'd4 : DEAD5;
			5'd3:  n = (c == CH_DOT) ? 5'd8 : (c == CH_MINUS) ? 5'd12 : DEAD5;
			5'd7:  n = (c == CH_RPAR) ? 5'd12 : DEAD5;
			5'd11: n = (c == CH_DOT) ? 5'd16 : DEAD5;
			5'd15: n = (c == CH_MINUS) ? 5'd16 : DEAD5;
			5'd1, 5'd2, 5'd4, 5'd5, 5'd6, 5'd8, 5'd9, 5'd10,
			5'd12, 5'd13, 5'd14, 5'd16, 5'd17, 5'd18, 5'd19:
				n = d ? s + 5'd1 : DEAD5;
			default: n = DEAD5;
		endcase
		return n;
	endfunction

	logic   valid_s1;
	byte_t  byte_s1;
	logic   last_s1;
	logic   adv;
	logic   out_valid_q;
	class_t class_q;

	st4_t sci_q;
	st3_t dec_q;
	st2_t int_q;
	st5_t kw_q;
	st2_t hex_q;
	st3_t chr_q;
	st4_t air_q;
	st2_t ident_q;
	st3_t str_q;
	st5_t phone_q;

	st4_t sci_d;
	st3_t dec_d;
	st2_t int_d;
	st5_t kw_d;
	st2_t hex_d;
	st3_t chr_d;
	st4_t air_d;
	st2_t ident_d;
	st3_t str_d;
	st5_t phone_d;
	class_t class_d;

	// handshake: a non-final byte never waits; a final one needs the result slot
	assign adv        = valid_s1 && (!last_s1 || !out_valid_q || !class_stall);
	assign byte_stall = valid_s1 && !adv;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!byte_stall) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!byte_stall && byte_valid) begin
			byte_s1 <= token_byte;
			last_s1 <= token_last;
		end
	end

	// next states of all recognizers
	always_comb begin
		sci_d   = nx_sci(sci_q, byte_s1);
		dec_d   = nx_dec(dec_q, byte_s1);
		int_d   = nx_int(int_q, byte_s1);
		kw_d    = nx_kw(kw_q, byte_s1);
		hex_d   = nx_hex(hex_q, byte_s1);
		chr_d   = nx_chr(chr_q, byte_s1);
		air_d   = nx_air(air_q, byte_s1);
		ident_d = nx_ident(ident_q, byte_s1);
		str_d   = nx_str(str_q, byte_s1);
		phone_d = nx_phone(phone_q, byte_s1);
	end

	// first accepting class in priority order
	always_comb begin
		priority if (sci_d == 4'd7) begin
			class_d = CLS_SCI;
		end else if (dec_d == 3'd4) begin
			class_d = CLS_DEC;
		end else if (int_d == 2'd2) begin
			class_d = CLS_INT;
		end else if (kw_d == 5'd8 || kw_d == 5'd10 || kw_d == 5'd14 || kw_d == 5'd16
			|| kw_d == 5'd21 || kw_d == 5'd25) begin
			class_d = CLS_KW;
		end else if (hex_d == 2'd2) begin
			class_d = CLS_HEX;
		end else if (chr_d == 3'd3) begin
			class_d = CLS_CHR;
		end else if (air_d == 4'd4 || air_d == 4'd5 || air_d == 4'd6 || air_d == 4'd8) begin
			class_d = CLS_AIR;
		end else if (ident_d == 2'd1) begin
			class_d = CLS_IDENT;
		end else if (str_d == 3'd3) begin
			class_d = CLS_STR;
		end else if (phone_d == 5'd20) begin
			class_d = CLS_PHONE;
		end else begin
			class_d = CLS_INVALID;
		end
	end

	// recognizer states; restart after the final byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sci_q   <= '0;
			dec_q   <= '0;
			int_q   <= '0;
			kw_q    <= '0;
			hex_q   <= '0;
			chr_q   <= '0;
			air_q   <= '0;
			ident_q <= '0;
			str_q   <= '0;
			phone_q <= '0;
		end else if (adv) begin
			if (last_s1) begin
				sci_q   <= '0;
				dec_q   <= '0;
				int_q   <= '0;
				kw_q    <= '0;
				hex_q   <= '0;
				chr_q   <= '0;
				air_q   <= '0;
				ident_q <= '0;
				str_q   <= '0;
				phone_q <= '0;
			end else begin
				sci_q   <= sci_d;
				dec_q   <= dec_d;
				int_q   <= int_d;
				kw_q    <= kw_d;
				hex_q   <= hex_d;
				chr_q   <= chr_d;
				air_q   <= air_d;
				ident_q <= ident_d;
				str_q   <= str_d;
				phone_q <= phone_d;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (!class_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && last_s1) begin
			class_q <= class_d;
		end
	end

	assign class_valid = out_valid_q;
	assign token_class = class_q;

endmodule

[rtl/tcr_checker.sv]
// Port-level checker for the token class recognizer, with its bind.
module tcr_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            byte_valid,
	input logic            byte_stall,
	input logic            token_last,
	input logic            class_valid,
	input logic            class_stall,
	input tcr_pkg::class_t token_class
);
	import tcr_pkg::*;

	// only defined class codes leave the block
	a_class_range: assert property (@(posedge clk) disable iff (!arst_n)
		class_valid |-> token_class <= CLS_PHONE)
		else $error("token_class out of range");

	// a fresh result follows a final byte that was taken earlier
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(class_valid) |-> $past(byte_valid && !byte_stall && token_last, 2))
		else $error("result without a preceding final byte");

	// with the result slot empty the input never waits
	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!class_valid |-> !byte_stall)
		else $error("input stalled while result slot empty");

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		class_valid && class_stall |=> class_valid && $stable(token_class))
		else $error("stalled result changed");

endmodule

bind token_class_recognizer tcr_checker u_tcr_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.byte_valid  (byte_valid),
	.byte_stall  (byte_stall),
	.token_last  (token_last),
	.class_valid (class_valid),
	.class_stall (class_stall),
	.token_class (token_class)
);

[bench/token_class_recognizer_test.sv]
// Self-checking bench for the token class recognizer: random token streams, class predictor.
module token_class_recognizer_test;
	import tcr_pkg::*;

	localparam int BYTE_COUNT  = 1950;
	localparam int DRAIN_EVERY = 500;
	localparam int CYCLE_LIMIT = 600000;

	// expected token classes, worked out byte by byte
	class class_scoreboard;
		st4_t sci_s;
		st3_t dec_s;
		st2_t int_s;
		st5_t kw_s;
		st2_t hex_s;
		st3_t chr_s;
		st4_t air_s;
		st2_t ident_s;
		st3_t str_s;
		st5_t phone_s;
		class_t pending_classes[$];
		int unsigned mismatches;

		function new();
			restart();
			mismatches = 0;
		endfunction

		function void restart();
			sci_s   = '0;
			dec_s   = '0;
			int_s   = '0;
			kw_s    = '0;
			hex_s   = '0;
			chr_s   = '0;
			air_s   = '0;
			ident_s = '0;
			str_s   = '0;
			phone_s = '0;
		endfunction

		function bit is_digit(byte_t c);
			return c >= "0" && c <= "9";
		endfunction

		function bit is_letter(byte_t c);
			return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
		endfunction

		function bit is_hex_digit(byte_t c);
			return is_digit(c) || (c >= "A" && c <= "F");
		endfunction

		function bit is_sign(byte_t c);
			return c == CH_MINUS || c == CH_PLUS;
		endfunction

		function bit is_air_prefix(byte_t c);
			return c == "A" || c == "G" || c == "J" || c == "D" || c == "P" || c == "L";
		endfunction

		function bit is_air_suffix(byte_t c);
			return c == "A" || c == "K" || c == "M" || c == "N" || c == "Y";
		endfunction

		// signed mantissa, fraction, E, signed exponent without leading zero
		function st4_t next_sci(st4_t s, byte_t c);
			case (s)
			4'd0: return is_digit(c) ? 4'd2 : is_sign(c) ? 4'd1 : DEAD4;
			4'd1: return is_digit(c) ? 4'd2 : DEAD4;
			4'd2: return is_digit(c) ? 4'd2 : c == CH_DOT ? 4'd3 : DEAD4;
			4'd3: return is_digit(c) ? 4'd4 : DEAD4;
			4'd4: return is_digit(c) ? 4'd4 : c == CH_E ? 4'd5 : DEAD4;
			4'd5: return (is_digit(c) && c != CH_ZERO) ? 4'd7 : is_sign(c) ? 4'd6 : DEAD4;
			4'd6: return (is_digit(c) && c != CH_ZERO) ? 4'd7 : DEAD4;
			4'd7: return is_digit(c) ? 4'd7 : DEAD4;
			default: return DEAD4;
			endcase
		endfunction

		function st3_t next_dec(st3_t s, byte_t c);
			case (s)
			3'd0: return is_digit(c) ? 3'd2 : is_sign(c) ? 3'd1 : DEAD3;
			3'd1: return is_digit(c) ? 3'd2 : DEAD3;
			3'd2: return is_digit(c) ? 3'd2 : c == CH_DOT ? 3'd3 : DEAD3;
			3'd3, 3'd4: return is_digit(c) ? 3'd4 : DEAD3;
			default: return DEAD3;
			endcase
		endfunction

		function st2_t next_int(st2_t s, byte_t c);
			case (s)
			2'd0: return is_digit(c) ? 2'd2 : is_sign(c) ? 2'd1 : DEAD2;
			2'd1, 2'd2: return is_digit(c) ? 2'd2 : DEAD2;
			default: return DEAD2;
			endcase
		endfunction

		// FUNCTION, IF, ELSE, END, WHILE, WRITE spelt out letter by letter
		function st5_t next_kw(st5_t s, byte_t c);
			case (s)
			5'd0: return c == "F" ? 5'd1 : c == "I" ? 5'd9 : c == CH_E ? 5'd11 :
				c == "W" ? 5'd17 : DEAD5;
			5'd1: return c == "U" ? 5'd2 : DEAD5;
			5'd2: return c == "N" ? 5'd3 : DEAD5;
			5'd3: return c == "C" ? 5'd4 : DEAD5;
			5'd4: return c == "T" ? 5'd5 : DEAD5;
			5'd5: return c == "I" ? 5'd6 : DEAD5;
			5'd6: return c == "O" ? 5'd7 : DEAD5;
			5'd7: return c == "N" ? 5'd8 : DEAD5;
			5'd9: return c == "F" ? 5'd10 : DEAD5;
			5'd11: return c == "L" ? 5'd12 : c == "N" ? 5'd15 : DEAD5;
			5'd12: return c == "S" ? 5'd13 : DEAD5;
			5'd13: return c == CH_E ? 5'd14 : DEAD5;
			5'd15: return c == "D" ? 5'd16 : DEAD5;
			5'd17: return c == CH_H ? 5'd18 : c == "R" ? 5'd22 : DEAD5;
			5'd18: return c == "I" ? 5'd19 : DEAD5;
			5'd19: return c == "L" ? 5'd20 : DEAD5;
			5'd20: return c == CH_E ? 5'd21 : DEAD5;
			5'd22: return c == "I" ? 5'd23 : DEAD5;
			5'd23: return c == "T" ? 5'd24 : DEAD5;
			5'd24: return c == CH_E ? 5'd25 : DEAD5;
			default: return DEAD5;
			endcase
		endfunction

		function st2_t next_hex(st2_t s, byte_t c);
			case (s)
			2'd0: return is_hex_digit(c) ? 2'd1 : DEAD2;
			2'd1: return is_hex_digit(c) ? 2'd1 : c == CH_H ? 2'd2 : DEAD2;
			default: return DEAD2;
			endcase
		endfunction

		function st3_t next_chr(st3_t s, byte_t c);
			case (s)
			3'd0: return is_hex_digit(c) ? 3'd1 : DEAD3;
			3'd1: return is_hex_digit(c) ? 3'd2 : DEAD3;
			3'd2: return c == CH_X ? 3'd3 : DEAD3;
			default: return DEAD3;
			endcase
		endfunction

		function st4_t next_air(st4_t s, byte_t c);
			case (s)
			4'd0: return is_air_prefix(c) ? 4'd1 : DEAD4;
			4'd1: return is_digit(c) ? 4'd2 : DEAD4;
			4'd2: return is_digit(c) ? 4'd3 : is_air_suffix(c) ? 4'd4 : DEAD4;
			4'd3: return is_air_suffix(c) ? 4'd4 : DEAD4;
			4'd4: return is_digit(c) ? 4'd5 : DEAD4;
			4'd5: return c == CH_MINUS ? 4'd7 : is_digit(c) ? 4'd6 : DEAD4;
			4'd6: return c == CH_MINUS ? 4'd7 : DEAD4;
			4'd7: return is_air_prefix(c) ? 4'd8 : DEAD4;
			default: return DEAD4;
			endcase
		endfunction

		function st2_t next_ident(st2_t s, byte_t c);
			case (s)
			2'd0: return is_letter(c) ? 2'd1 : DEAD2;
			2'd1: return (is_letter(c) || is_digit(c) || c == CH_UNDER) ? 2'd1 : DEAD2;
			default: return DEAD2;
			endcase
		endfunction

		// any byte but space and quote counts as string body, NUL and high bytes too
		function st3_t next_str(st3_t s, byte_t c);
			bit body;
			body = c != CH_SPACE && c != CH_QUOTE;
			case (s)
			3'd0: return c == CH_QUOTE ? 3'd1 : DEAD3;
			3'd1: return body ? 3'd2 : DEAD3;
			3'd2: return body ? 3'd2 : c == CH_QUOTE ? 3'd3 : DEAD3;
			default: return DEAD3;
			endcase
		endfunction

		function st5_t next_phone(st5_t s, byte_t c);
			bit d;
			d = is_digit(c);
			case (s)
			5'd0: return d ? 5'd1 : c == CH_LPAR ? 5'd4 : DEAD5;
			5'd3: return c == CH_DOT ? 5'd8 : c == CH_MINUS ? 5'd12 : DEAD5;
			5'd7: return c == CH_RPAR ? 5'd12 : DEAD5;
			5'd11: return c == CH_DOT ? 5'd16 : DEAD5;
			5'd15: return c == CH_MINUS ? 5'd16 : DEAD5;
			5'd1, 5'd2, 5'd4, 5'd5, 5'd6, 5'd8, 5'd9, 5'd10,
			5'd12, 5'd13, 5'd14, 5'd16, 5'd17, 5'd18, 5'd19:
				return d ? st5_t'(s + 5'd1) : DEAD5;
			default: return DEAD5;
			endcase
		endfunction

		// advance all recognisers; on the final byte queue the winning class
		function void take_byte(byte_t c, logic last);
			class_t cls;
			sci_s   = next_sci(sci_s, c);
			dec_s   = next_dec(dec_s, c);
			int_s   = next_int(int_s, c);
			kw_s    = next_kw(kw_s, c);
			hex_s   = next_hex(hex_s, c);
			chr_s   = next_chr(chr_s, c);
			air_s   = next_air(air_s, c);
			ident_s = next_ident(ident_s, c);
			str_s   = next_str(str_s, c);
			phone_s = next_phone(phone_s, c);
			if (!last)
				return;
			if (sci_s == 4'd7)
				cls = CLS_SCI;
			else if (dec_s == 3'd4)
				cls = CLS_DEC;
			else if (int_s == 2'd2)
				cls = CLS_INT;
			else if (kw_s == 5'd8 || kw_s == 5'd10 || kw_s == 5'd14 ||
				kw_s == 5'd16 || kw_s == 5'd21 || kw_s == 5'd25)
				cls = CLS_KW;
			else if (hex_s == 2'd2)
				cls = CLS_HEX;
			else if (chr_s == 3'd3)
				cls = CLS_CHR;
			else if (air_s == 4'd4 || air_s == 4'd5 || air_s == 4'd6 || air_s == 4'd8)
				cls = CLS_AIR;
			else if (ident_s == 2'd1)
				cls = CLS_IDENT;
			else if (str_s == 3'd3)
				cls = CLS_STR;
			else if (phone_s == 5'd20)
				cls = CLS_PHONE;
			else
				cls = CLS_INVALID;
			pending_classes.push_back(cls);
			restart();
		endfunction

		function void check_class(class_t got);
			class_t want;
			if (pending_classes.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("class %0d delivered with no token outstanding", got);
				return;
			end
			want = pending_classes.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10)
					$display("token class mismatch: expected %0d, got %0d", want, got);
			end
		endfunction
	endclass

	logic   clk         = 1'b0;
	logic   arst_n      = 1'b0;
	logic   byte_valid  = 1'b0;
	byte_t  token_byte  = '0;
	logic   token_last  = 1'b0;
	logic   class_stall = 1'b0;
	logic   byte_stall;
	logic   class_valid;
	class_t token_class;

	class_scoreboard sb;
	byte_t token_q[$];
	bit calm = 1'b0;
	int stall_left = 0;
	int stall_pick;
	int unsigned cycles = 0;
	string keywords[6] = '{"FUNCTION", "IF", "ELSE", "END", "WHILE", "WRITE"};

	token_class_recognizer dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.byte_valid  (byte_valid),
		.byte_stall  (byte_stall),
		.token_byte  (token_byte),
		.token_last  (token_last),
		.class_valid (class_valid),
		.class_stall (class_stall),
		.token_class (token_class)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("token_class_recognizer verification failed");
			$finish;
		end
	end

	// result side: check what was taken at this edge, then choose the next stall
	always @(posedge clk) begin
		if (arst_n && class_valid && !class_stall)
			sb.check_class(token_class);
		if (calm || !arst_n) begin
			class_stall <= 1'b0;
		end else if (stall_left != 0) begin
			stall_left--;
			class_stall <= 1'b1;
		end else begin
			stall_pick = $urandom_range(0, 99);
			if (stall_pick < 75) begin
				class_stall <= 1'b0;
			end else begin
				stall_left = (stall_pick < 96) ? $urandom_range(0, 2) : $urandom_range(9, 29);
				class_stall <= 1'b1;
			end
		end
	end

	function automatic byte_t pick_digit();
		return byte_t'(CH_ZERO + $urandom_range(0, 9));
	endfunction

	function automatic byte_t pick_from(string s);
		return s[$urandom_range(0, s.len() - 1)];
	endfunction

	function automatic byte_t pick_letter();
		int r;
		r = $urandom_range(0, 51);
		return (r < 26) ? byte_t'("A" + r) : byte_t'("a" + r - 26);
	endfunction

	function automatic byte_t pick_body();
		byte_t b;
		do
			b = byte_t'($urandom_range(0, 255));
		while (b == CH_SPACE || b == CH_QUOTE);
		return b;
	endfunction

	function automatic void push_digits(int n);
		for (int i = 0; i < n; i++)
			token_q.push_back(pick_digit());
	endfunction

	function automatic void push_sign();
		token_q.push_back($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
	endfunction

	// mostly well-formed tokens of a random class, some damaged, some plain noise
	function automatic void form_token();
		string kw;
		int n;
		int damage;
		token_q.delete();
		case ($urandom_range(0, 9))
		0: begin
			if ($urandom_range(0, 1)) push_sign();
			push_digits($urandom_range(1, 3));
			token_q.push_back(CH_DOT);
			push_digits($urandom_range(1, 3));
			token_q.push_back(CH_E);
			if ($urandom_range(0, 1)) push_sign();
			token_q.push_back(pick_from("123456789"));
			push_digits($urandom_range(0, 2));
		end
		1: begin
			if ($urandom_range(0, 1)) push_sign();
			push_digits($urandom_range(1, 3));
			token_q.push_back(CH_DOT);
			push_digits($urandom_range(1, 3));
		end
		2: begin
			if ($urandom_range(0, 1)) push_sign();
			push_digits($urandom_range(1, 4));
		end
		3: begin
			kw = keywords[$urandom_range(0, 5)];
			for (int i = 0; i < kw.len(); i++)
				token_q.push_back(kw[i]);
		end
		4: begin
			n = $urandom_range(1, 4);
			for (int i = 0; i < n; i++)
				token_q.push_back(pick_from("0123456789ABCDEF"));
			token_q.push_back(CH_H);
		end
		5: begin
			token_q.push_back(pick_from("0123456789ABCDEF"));
			token_q.push_back(pick_from("0123456789ABCDEF"));
			token_q.push_back(CH_X);
		end
		6: begin
			token_q.push_back(pick_from("AGJDPL"));
			push_digits($urandom_range(1, 2));
			token_q.push_back(pick_from("AKMNY"));
			n = $urandom_range(0, 4);
			if (n != 0) push_digits((n == 2 || n == 4) ? 2 : 1);
			if (n >= 3) begin
				token_q.push_back(CH_MINUS);
				token_q.push_back(pick_from("AGJDPL"));
			end
		end
		7: begin
			token_q.push_back(pick_letter());
			n = $urandom_range(0, 5);
			for (int i = 0; i < n; i++)
				case ($urandom_range(0, 3))
				0: token_q.push_back(pick_digit());
				1: token_q.push_back(CH_UNDER);
				default: token_q.push_back(pick_letter());
				endcase
		end
		8: begin
			token_q.push_back(CH_QUOTE);
			n = $urandom_range(1, 5);
			for (int i = 0; i < n; i++)
				token_q.push_back(pick_body());
			token_q.push_back(CH_QUOTE);
		end
		default: begin
			n = $urandom_range(0, 2);
			if (n == 2) token_q.push_back(CH_LPAR);
			push_digits(3);
			token_q.push_back(n == 0 ? CH_DOT : n == 1 ? CH_MINUS : CH_RPAR);
			push_digits(3);
			token_q.push_back(n == 0 ? CH_DOT : CH_MINUS);
			push_digits(4);
		end
		endcase
		damage = $urandom_range(0, 99);
		if (damage >= 70 && damage < 80) begin
			token_q[$urandom_range(0, token_q.size() - 1)] = byte_t'($urandom_range(0, 255));
		end else if (damage >= 80 && damage < 85 && token_q.size() > 1) begin
			token_q.delete(token_q.size() - 1);
		end else if (damage >= 85 && damage < 88 && token_q.size() > 1) begin
			token_q.delete(0);
		end else if (damage >= 88) begin
			token_q.delete();
			n = $urandom_range(1, 6);
			for (int i = 0; i < n; i++)
				token_q.push_back(byte_t'($urandom_range(0, 255)));
		end
	endfunction

	// sender gap after an accepted item: mostly none, a few long ones
	task automatic pause_sender();
		int r;
		int n;
		r = $urandom_range(0, 99);
		n = 0;
		if (!calm) begin
			if (r >= 70 && r < 95)
				n = $urandom_range(1, 3);
			else if (r >= 95)
				n = $urandom_range(8, 40);
		end
		if (n != 0) begin
			byte_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic send_byte(byte_t b, logic last);
		byte_valid <= 1'b1;
		token_byte <= b;
		token_last <= last;
		do
			@(posedge clk);
		while (byte_stall);
		sb.take_byte(b, last);
		pause_sender();
	endtask

	task automatic send_token();
		for (int i = 0; i < token_q.size(); i++)
			send_byte(token_q[i], i == token_q.size() - 1);
	endtask

	task automatic send_text(string s);
		token_q.delete();
		for (int i = 0; i < s.len(); i++)
			token_q.push_back(s[i]);
		send_token();
	endtask

	// hold the sender until every outstanding class has come back
	task automatic wait_results();
		byte_valid <= 1'b0;
		while (sb.pending_classes.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		int sent;
		int next_drain;
		sb = new();
		sent = 0;
		next_drain = DRAIN_EVERY;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed tokens: one of several classes, single bytes, NUL and high bytes
		send_text("1.5E3");
		send_text("-2.5");
		send_text("7");
		send_text("IF");
		send_text("FFH");
		send_text("1AX");
		send_text("A1N2");
		send_text("x");
		token_q = '{CH_QUOTE, 8'h80, 8'h00, 8'hFF, CH_QUOTE};
		send_token();
		send_byte(8'h00, 1'b1);
		send_byte(8'hFF, 1'b1);
		wait_results();

		// random token stream
		while (sent < BYTE_COUNT) begin
			if ($urandom_range(0, 29) == 0)
				calm = !calm;
			form_token();
			send_token();
			sent += token_q.size();
			if (sent >= next_drain) begin
				wait_results();
				next_drain += DRAIN_EVERY;
			end
		end

		wait_results();
		repeat (8) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending_classes.size() == 0)
			$display("token_class_recognizer verification clean");
		else
			$display("token_class_recognizer verification failed");
		$finish;
	end

endmodule
